>>> src/periodic_hook_scheduler_stats_assert.svh
// Assertion macros shared by the periodic hook scheduler RTL.
// No dependencies; included inside module bodies.
`ifndef PERIODIC_HOOK_SCHEDULER_STATS_ASSERT_SVH
`define PERIODIC_HOOK_SCHEDULER_STATS_ASSERT_SVH

// property must hold at every edge out of reset
`define PHS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen out of reset
`define PHS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> src/phs_pkg.sv
// Package for the periodic hook scheduler: codes, beat types, token format.
// No dependencies.
`default_nettype none
package phs_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned MAX_FIRES     = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_REG   = 2'd1;
  localparam logic [1:0] OP_UNREG = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNUSED  = 2'd2;
  localparam logic [1:0] ST_STOPPED = 2'd3;

  localparam logic [3:0] SEL_E_CNT  = 4'd0;
  localparam logic [3:0] SEL_E_SUM  = 4'd1;
  localparam logic [3:0] SEL_E_SUM2 = 4'd2;
  localparam logic [3:0] SEL_E_MIN  = 4'd3;
  localparam logic [3:0] SEL_E_MAX  = 4'd4;
  localparam logic [3:0] SEL_L_CNT  = 4'd5;
  localparam logic [3:0] SEL_L_SUM  = 4'd6;
  localparam logic [3:0] SEL_L_SUM2 = 4'd7;
  localparam logic [3:0] SEL_L_MIN  = 4'd8;
  localparam logic [3:0] SEL_L_MAX  = 4'd9;
  localparam logic [3:0] SEL_FIRES  = 4'd10;
  localparam logic [3:0] SEL_PERIOD = 4'd11;
  localparam logic [3:0] SEL_LAST   = 4'd12;
  localparam logic [3:0] SEL_TICKS  = 4'd13;

  localparam logic [2:0] ADDR_RUNNING = 3'd0;

  typedef struct packed {
    logic [63:0] cnt;
    logic [63:0] sum;
    logic [63:0] sum2;
    logic [63:0] mn;
    logic [63:0] mx;
  } stats_t;

  // operation travelling along the row of cells
  typedef struct packed {
    logic        valid;
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [63:0] period;
    logic [63:0] now;
    logic [3:0]  sel;
    logic        hit;
    logic [3:0]  res_slot;
    logic [63:0] value;
  } tok_t;

  typedef struct packed {
    logic       fire;
    logic [3:0] slot;
  } evt_t;

endpackage
`default_nettype wire

>>> src/phs_ifs.sv
// Valid/ready channel interfaces for the hook scheduler input and result beats.
// No dependencies.
`default_nettype none
interface phs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  slot;
  logic [63:0] period;
  logic [63:0] now;
  logic [3:0]  stat_select;
  modport source (output valid, opcode, slot, period, now, stat_select, input ready);
  modport sink   (input valid, opcode, slot, period, now, stat_select, output ready);
endinterface

interface phs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot_out;
  logic        fired;
  logic [63:0] value;
  logic        last;
  modport source (output valid, status, slot_out, fired, value, last, input ready);
  modport sink   (input valid, status, slot_out, fired, value, last, output ready);
endinterface
`default_nettype wire

>>> src/phs_cell.sv
// One hook slot: period, last fire, fire count and jitter statistics.
// Depends on phs_pkg; passes the operation token on each advance.
`default_nettype none
module phs_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             adv_i,
  input  phs_pkg::tok_t   tok_i,
  output phs_pkg::tok_t   tok_o,
  output phs_pkg::evt_t   evt_o
);
  import phs_pkg::*;

  logic        en_q, en_d;
  logic [63:0] period_q, last_q, fc_q;
  stats_t      es_q, ls_q;
  tok_t        tok_q, tok_d;
  evt_t        evt_q, evt_d;

  logic        ra_vld_q, ra_late_q;
  logic [63:0] ra_v_q;
  logic        rb_vld_q, rb_late_q;
  logic [63:0] rb_v_q, rb_pl_q, rb_px_q;

  logic        mine, tick, fire;
  logic [63:0] due, v_d, sq, stat;
  stats_t      rec_s, clr_s;

  assign mine = (32'(tok_i.slot) == CELL_IDX);
  assign due  = last_q + period_q;
  assign tick = tok_i.valid && (tok_i.op == OP_TICK) && en_q;
  assign fire = tick && (tok_i.now >= due);
  assign v_d  = fire ? (tok_i.now - due) : (due - tok_i.now);
  assign sq   = rb_pl_q + {rb_px_q[30:0], 33'b0};

  assign clr_s = '{cnt: '0, sum: '0, sum2: '0, mn: '1, mx: '0};

  always_comb begin
    rec_s      = rb_late_q ? ls_q : es_q;
    rec_s.cnt  = rec_s.cnt + 64'd1;
    rec_s.sum  = rec_s.sum + rb_v_q;
    rec_s.sum2 = rec_s.sum2 + sq;
    if (rb_v_q < rec_s.mn) rec_s.mn = rb_v_q;
    if (rb_v_q > rec_s.mx) rec_s.mx = rb_v_q;
  end

  always_comb begin
    case (tok_i.sel)
      SEL_E_CNT:  stat = es_q.cnt;
      SEL_E_SUM:  stat = es_q.sum;
      SEL_E_SUM2: stat = es_q.sum2;
      SEL_E_MIN:  stat = es_q.mn;
      SEL_E_MAX:  stat = es_q.mx;
      SEL_L_CNT:  stat = ls_q.cnt;
      SEL_L_SUM:  stat = ls_q.sum;
      SEL_L_SUM2: stat = ls_q.sum2;
      SEL_L_MIN:  stat = ls_q.mn;
      SEL_L_MAX:  stat = ls_q.mx;
      SEL_FIRES:  stat = fc_q;
      SEL_PERIOD: stat = period_q;
      SEL_LAST:   stat = last_q;
      default:    stat = '0;
    endcase
  end

  always_comb begin
    tok_d = tok_i;
    en_d  = en_q;
    evt_d = '{fire: fire, slot: fire ? 4'(CELL_IDX) : 4'd0};
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_REG: begin
          if (!tok_i.hit && !en_q) begin
            tok_d.hit      = 1'b1;
            tok_d.res_slot = 4'(CELL_IDX);
            en_d           = 1'b1;
          end
        end
        OP_UNREG: begin
          if (mine && en_q) begin
            tok_d.hit = 1'b1;
            en_d      = 1'b0;
          end
        end
        OP_READ: begin
          if (mine) begin
            tok_d.hit   = en_q;
            tok_d.value = en_q ? stat : 64'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      tok_q    <= '0;
      evt_q    <= '0;
      ra_vld_q <= 1'b0;
      rb_vld_q <= 1'b0;
    end else if (adv_i) begin
      en_q     <= en_d;
      tok_q    <= tok_d;
      evt_q    <= evt_d;
      ra_vld_q <= tick && !(fire && (fc_q == 64'd0));
      rb_vld_q <= ra_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ra_late_q <= fire;
      ra_v_q    <= v_d;
      rb_late_q <= ra_late_q;
      rb_v_q    <= ra_v_q;
      rb_pl_q   <= 64'(ra_v_q[31:0]) * 64'(ra_v_q[31:0]);
      rb_px_q   <= 64'(ra_v_q[31:0]) * 64'(ra_v_q[63:32]);
      if (fire) begin
        last_q <= tok_i.now;
        fc_q   <= fc_q + 64'd1;
      end
      if (tok_i.valid && (tok_i.op == OP_REG) && !tok_i.hit && !en_q) begin
        period_q <= tok_i.period;
        last_q   <= 64'd0;
        fc_q     <= 64'd0;
        es_q     <= clr_s;
        ls_q     <= clr_s;
      end else if (rb_vld_q) begin
        if (rb_late_q) ls_q <= rec_s;
        else           es_q <= rec_s;
      end
    end
  end

  assign tok_o = tok_q;
  assign evt_o = evt_q;

endmodule
`default_nettype wire

>>> src/periodic_hook_scheduler_stats.sv
// Top level of the periodic hook scheduler: control, result register, APB.
// Depends on phs_pkg, phs_ifs, phs_cell and the assertion header.
// Operations walk a row of NUM_SLOTS slot cells, one cell per cycle while
// results are not held back; a tick, register, unregister or statistic read
// has its final result once the token leaves the last cell, and the next
// item is not taken until that result is registered. A tick while stopped
// and a tick-count read are answered at acceptance. One item is in flight at
// a time; fire results leave in slot order, at most sixteen.
`default_nettype none
module periodic_hook_scheduler_stats #(
  parameter int unsigned NUM_SLOTS = phs_pkg::NUM_SLOTS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  phs_in_if.sink       in_i,
  phs_out_if.source    out_o,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import phs_pkg::*;

  `include "periodic_hook_scheduler_stats_assert.svh"

  logic        running_q;
  logic [63:0] tick_cnt_q;
  logic        busy_q, fin_q, pend_vld_q;
  logic [3:0]  pend_slot_q;
  logic [4:0]  nfire_q;
  tok_t        fin_tok_q;

  logic        out_vld_q;
  logic [1:0]  out_status_q;
  logic [3:0]  out_slot_q;
  logic        out_fired_q, out_last_q;
  logic [63:0] out_value_q;

  tok_t        toks [NUM_SLOTS+1];
  evt_t        evts [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] fire_vec, tok_vld_vec;
  logic        any_fire;
  logic [3:0]  fire_slot;

  logic        adv, acc, imm, take_fire;
  logic        emit, e_fired, e_last;
  logic [1:0]  e_status;
  logic [3:0]  e_slot;
  logic [63:0] e_value;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_RUNNING) ? {31'd0, running_q} : 32'd0;

  assign adv = !out_vld_q || out_o.ready;
  assign in_i.ready = !busy_q && adv;
  assign acc = in_i.valid && in_i.ready;
  assign imm = ((in_i.opcode == OP_TICK) && !running_q) ||
               ((in_i.opcode == OP_READ) && (in_i.stat_select == SEL_TICKS));

  assign toks[0] = '{valid: acc && !imm, op: in_i.opcode, slot: in_i.slot,
                     period: in_i.period, now: in_i.now, sel: in_i.stat_select,
                     hit: 1'b0, res_slot: 4'd0, value: 64'd0};

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    phs_cell #(.CELL_IDX(g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (toks[g]),
      .tok_o (toks[g+1]),
      .evt_o (evts[g])
    );
    assign fire_vec[g]    = evts[g].fire;
    assign tok_vld_vec[g] = toks[g+1].valid;
  end

  always_comb begin
    fire_slot = 4'd0;
    for (int i = 0; i < NUM_SLOTS; i++) fire_slot = fire_slot | evts[i].slot;
  end
  assign any_fire  = |fire_vec;
  assign take_fire = busy_q && any_fire && (32'(nfire_q) < MAX_FIRES);

  always_comb begin
    emit = 1'b0; e_status = ST_OK; e_slot = 4'd0; e_fired = 1'b0;
    e_value = 64'd0; e_last = 1'b1;
    if (acc && imm) begin
      emit = 1'b1;
      if (in_i.opcode == OP_TICK) begin
        e_status = ST_STOPPED;
      end else begin
        e_slot  = in_i.slot;
        e_value = tick_cnt_q;
      end
    end else if (fin_q) begin
      emit = 1'b1;
      case (fin_tok_q.op)
        OP_TICK: begin
          e_slot  = pend_vld_q ? pend_slot_q : 4'd0;
          e_fired = pend_vld_q;
        end
        OP_REG: begin
          e_status = fin_tok_q.hit ? ST_OK : ST_FULL;
          e_slot   = fin_tok_q.hit ? fin_tok_q.res_slot : 4'd0;
        end
        default: begin
          e_status = fin_tok_q.hit ? ST_OK : ST_UNUSED;
          e_slot   = fin_tok_q.slot;
          e_value  = fin_tok_q.value;
        end
      endcase
    end else if (take_fire && pend_vld_q) begin
      emit    = 1'b1;
      e_slot  = pend_slot_q;
      e_fired = 1'b1;
      e_last  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      tick_cnt_q <= 64'd0;
      busy_q     <= 1'b0;
      fin_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      nfire_q    <= 5'd0;
      out_vld_q  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr == ADDR_RUNNING)) running_q <= pwdata[0];
      if (adv) begin
        out_vld_q <= emit;
        if (acc && (in_i.opcode == OP_TICK) && running_q) tick_cnt_q <= tick_cnt_q + 64'd1;
        if (acc && !imm) begin
          busy_q     <= 1'b1;
          pend_vld_q <= 1'b0;
          nfire_q    <= 5'd0;
        end
        if (take_fire) begin
          pend_vld_q <= 1'b1;
          nfire_q    <= nfire_q + 5'd1;
        end
        if (busy_q && toks[NUM_SLOTS].valid) fin_q <= 1'b1;
        if (fin_q) begin
          fin_q  <= 1'b0;
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (emit) begin
        out_status_q <= e_status;
        out_slot_q   <= e_slot;
        out_fired_q  <= e_fired;
        out_value_q  <= e_value;
        out_last_q   <= e_last;
      end
      if (take_fire) pend_slot_q <= fire_slot;
      if (toks[NUM_SLOTS].valid) fin_tok_q <= toks[NUM_SLOTS];
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.status   = out_status_q;
  assign out_o.slot_out = out_slot_q;
  assign out_o.fired    = out_fired_q;
  assign out_o.value    = out_value_q;
  assign out_o.last     = out_last_q;

  `PHS_ASSERT(a_acc_answers, clk_i, rst_ni, acc |=> (busy_q || out_vld_q), "beat dropped")
  `PHS_ASSERT(a_one_fire, clk_i, rst_ni, $countones(fire_vec) <= 1, "two cells fired at once")
  `PHS_ASSERT_NEVER(a_idle_empty, clk_i, rst_ni, !busy_q && (|tok_vld_vec), "stray token")

endmodule
`default_nettype wire
